FILE: rtl/mhdc_pkg.sv
// Shared constants for the MHD conserved-to-primitive converter.
`timescale 1ns / 1ps
package mhdc_pkg;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int GAMMA_RESET = 43691;
  localparam int FLOOR_RESET = 1;
  localparam int INDEX_W = 1;
  localparam logic [INDEX_W-1:0] REG_GAMMA = 1'b0;
  localparam logic [INDEX_W-1:0] REG_FLOOR = 1'b1;
endpackage

FILE: rtl/mhdc_if.sv
// Valid/ready channel interfaces for cell beats in and out.
`timescale 1ns / 1ps
interface mhdc_in_if #(parameter int W = 32);
  logic valid;
  logic ready;
  logic signed [W-1:0] density;
  logic signed [W-1:0] momentum_x;
  logic signed [W-1:0] momentum_y;
  logic signed [W-1:0] momentum_z;
  logic signed [W-1:0] total_energy;
  logic signed [W-1:0] field_x;
  logic signed [W-1:0] field_y;
  logic signed [W-1:0] field_z;
  modport source (output valid, density, momentum_x, momentum_y, momentum_z,
                  total_energy, field_x, field_y, field_z, input ready);
  modport sink (input valid, density, momentum_x, momentum_y, momentum_z,
                total_energy, field_x, field_y, field_z, output ready);
endinterface

interface mhdc_out_if #(parameter int W = 32);
  logic valid;
  logic ready;
  logic signed [W-1:0] out_density;
  logic signed [W-1:0] velocity_x;
  logic signed [W-1:0] velocity_y;
  logic signed [W-1:0] velocity_z;
  logic [W-2:0] pressure;
  logic signed [W-1:0] out_field_x;
  logic signed [W-1:0] out_field_y;
  logic signed [W-1:0] out_field_z;
  logic floor_applied;
  logic density_error;
  modport source (output valid, out_density, velocity_x, velocity_y, velocity_z, pressure,
                  out_field_x, out_field_y, out_field_z, floor_applied, density_error,
                  input ready);
  modport sink (input valid, out_density, velocity_x, velocity_y, velocity_z, pressure,
                out_field_x, out_field_y, out_field_z, floor_applied, density_error,
                output ready);
endinterface

FILE: rtl/mhdc_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module mhdc_div #(
  parameter int W = mhdc_pkg::DATA_WIDTH_DEF,
  parameter int F = mhdc_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [W+F-1:0]       num,
  input  logic [W-1:0]         den,
  output logic [W+F-1:0]       quo
);
  import mhdc_pkg::*;
  localparam int NW = W + F;

  logic [W-1:0]  rem_q [NW];
  logic [NW-1:0] num_q [NW];
  logic [NW-1:0] quo_q [NW];
  logic [W-1:0]  den_q [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [W-1:0]  rem_in;
    logic [NW-1:0] num_in;
    logic [NW-1:0] quo_in;
    logic [W-1:0]  den_in;
    logic [W:0]    trial;
    logic [W+1:0]  diff;
    logic          ge;
    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num;
      assign quo_in = '0;
      assign den_in = den;
    end else begin : g_rest
      assign rem_in = rem_q[k-1];
      assign num_in = num_q[k-1];
      assign quo_in = quo_q[k-1];
      assign den_in = den_q[k-1];
    end
    assign trial = {rem_in, num_in[NW-1]};
    assign diff = {1'b0, trial} - {2'b00, den_in};
    assign ge = ~diff[W+1];
    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= ge ? diff[W-1:0] : trial[W-1:0];
        num_q[k] <= {num_in[NW-2:0], 1'b0};
        quo_q[k] <= {quo_in[NW-2:0], ge};
        den_q[k] <= den_in;
      end
    end
  end

  assign quo = quo_q[NW-1];
endmodule

FILE: rtl/mhdc_energy.sv
// Velocity saturation, kinetic and magnetic energy, pressure and floor stages.
`timescale 1ns / 1ps
module mhdc_energy #(
  parameter int W = mhdc_pkg::DATA_WIDTH_DEF,
  parameter int F = mhdc_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                vld_in,
  input  logic [W+F-1:0]      quo_x,
  input  logic [W+F-1:0]      quo_y,
  input  logic [W+F-1:0]      quo_z,
  input  logic                neg_x,
  input  logic                neg_y,
  input  logic                neg_z,
  input  logic                derr_in,
  input  logic signed [W-1:0] d_in,
  input  logic signed [W-1:0] e_in,
  input  logic signed [W-1:0] bx_in,
  input  logic signed [W-1:0] by_in,
  input  logic signed [W-1:0] bz_in,
  input  logic [W-2:0]        gamma_minus_one,
  input  logic [W-2:0]        pressure_floor,
  output logic                vld_out,
  output logic signed [W-1:0] d_out,
  output logic signed [W-1:0] vx_out,
  output logic signed [W-1:0] vy_out,
  output logic signed [W-1:0] vz_out,
  output logic [W-2:0]        p_out,
  output logic signed [W-1:0] bx_out,
  output logic signed [W-1:0] by_out,
  output logic signed [W-1:0] bz_out,
  output logic                floor_out,
  output logic                derr_out
);
  import mhdc_pkg::*;
  localparam int NS = 7;
  localparam int XW = 2 * W + 2;
  localparam int RW = 2 * W - F;
  localparam logic signed [XW-1:0] DMAX_X = {{(W+3){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [XW-1:0] DMIN_X = {{(W+3){1'b1}}, {(W-1){1'b0}}};
  localparam logic signed [RW-1:0] PMAX_R = {{(W-F+1){1'b0}}, {(W-1){1'b1}}};

  function automatic logic signed [W-1:0] sat_w(input logic signed [XW-1:0] x);
    logic signed [W-1:0] r;
    if (x > DMAX_X) r = DMAX_X[W-1:0];
    else if (x < DMIN_X) r = DMIN_X[W-1:0];
    else r = x[W-1:0];
    return r;
  endfunction

  function automatic logic signed [W-1:0] sat_q(input logic [W+F-1:0] q, input logic neg);
    logic signed [XW-1:0] s;
    s = XW'(q);
    if (neg) s = -s;
    return sat_w(s);
  endfunction

  function automatic logic signed [W-1:0] sq_sat(input logic signed [2*W-1:0] p);
    logic [2*W-1:0] u;
    u = p;
    return sat_w(XW'(u >> F));
  endfunction

  logic               vld_q  [NS];
  logic signed [W-1:0] d_q   [NS];
  logic signed [W-1:0] bx_q  [NS];
  logic signed [W-1:0] by_q  [NS];
  logic signed [W-1:0] bz_q  [NS];
  logic               derr_q [NS];
  logic signed [W-1:0] e_q   [4];

  logic signed [W-1:0]   v1x, v1y, v1z, v2x, v2y, v2z, v3x, v3y, v3z;
  logic signed [2*W-1:0] bsqx, bsqy, bsqz, vsqx, vsqy, vsqz;
  logic signed [W-1:0]   mag2, mag3, mag4, vsum3, internal5;
  logic signed [2*W-1:0] kprod4, gprod6;
  logic signed [W-1:0]   kin_c, mag_c, vsum_c, internal_c;
  logic signed [RW-1:0]  raw_c;
  logic [W-2:0]          p_c;
  logic                  floor_c;

  always_comb begin
    mag_c = sat_w(XW'(sq_sat(bsqx)) + XW'(sq_sat(bsqy)) + XW'(sq_sat(bsqz))) >>> 1;
    vsum_c = sat_w(XW'(sq_sat(vsqx)) + XW'(sq_sat(vsqy)) + XW'(sq_sat(vsqz)));
    kin_c = sat_w(XW'(kprod4 >>> (F + 1)));
    internal_c = sat_w(XW'(e_q[3]) - XW'(kin_c) - XW'(mag4));
    raw_c = RW'(gprod6 >>> F);
    if (raw_c < $signed({{(W-F+1){1'b0}}, pressure_floor})) begin
      p_c = pressure_floor;
      floor_c = 1'b1;
    end else if (raw_c > PMAX_R) begin
      p_c = PMAX_R[W-2:0];
      floor_c = 1'b0;
    end else begin
      p_c = raw_c[W-2:0];
      floor_c = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NS; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= vld_in;
      for (int k = 1; k < NS; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_q[0] <= d_in;
      bx_q[0] <= bx_in;
      by_q[0] <= by_in;
      bz_q[0] <= bz_in;
      derr_q[0] <= derr_in;
      e_q[0] <= e_in;
      for (int k = 1; k < NS; k++) begin
        d_q[k] <= d_q[k-1];
        bx_q[k] <= bx_q[k-1];
        by_q[k] <= by_q[k-1];
        bz_q[k] <= bz_q[k-1];
        derr_q[k] <= derr_q[k-1];
      end
      for (int k = 1; k < 4; k++) e_q[k] <= e_q[k-1];
      v1x <= derr_in ? '0 : sat_q(quo_x, neg_x);
      v1y <= derr_in ? '0 : sat_q(quo_y, neg_y);
      v1z <= derr_in ? '0 : sat_q(quo_z, neg_z);
      bsqx <= bx_in * bx_in;
      bsqy <= by_in * by_in;
      bsqz <= bz_in * bz_in;
      vsqx <= v1x * v1x;
      vsqy <= v1y * v1y;
      vsqz <= v1z * v1z;
      v2x <= v1x;
      v2y <= v1y;
      v2z <= v1z;
      mag2 <= mag_c;
      vsum3 <= vsum_c;
      mag3 <= mag2;
      v3x <= v2x;
      v3y <= v2y;
      v3z <= v2z;
      kprod4 <= d_q[2] * vsum3;
      mag4 <= mag3;
      internal5 <= internal_c;
      gprod6 <= internal5 * $signed({1'b0, gamma_minus_one});
      p_out <= p_c;
      floor_out <= floor_c;
    end
  end

  logic signed [W-1:0] vx_d [4];
  logic signed [W-1:0] vy_d [4];
  logic signed [W-1:0] vz_d [4];
  always_ff @(posedge clk) begin
    if (en) begin
      vx_d[0] <= v3x;
      vy_d[0] <= v3y;
      vz_d[0] <= v3z;
      for (int k = 1; k < 4; k++) begin
        vx_d[k] <= vx_d[k-1];
        vy_d[k] <= vy_d[k-1];
        vz_d[k] <= vz_d[k-1];
      end
    end
  end

  assign vld_out = vld_q[NS-1];
  assign d_out = d_q[NS-1];
  assign bx_out = bx_q[NS-1];
  assign by_out = by_q[NS-1];
  assign bz_out = bz_q[NS-1];
  assign derr_out = derr_q[NS-1];
  assign vx_out = vx_d[3];
  assign vy_out = vy_d[3];
  assign vz_out = vz_d[3];
endmodule

FILE: rtl/mhd_conserved_to_primitive.sv
// A beat passes the input register, the velocity dividers, then the energy stages; default is Q16.16.
// Throughput: one cell per cycle unless stalled; one quotient bit per divider stage sets depth.
// The whole pipeline holds while an output beat waits and takes input again when it moves.
// Reset clears all valid bits and loads gamma_minus_one = 2/3 and pressure_floor = 1 LSB.
`timescale 1ns / 1ps
module mhd_conserved_to_primitive #(
  parameter int DATA_WIDTH = mhdc_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS = mhdc_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  mhdc_in_if.sink                     cell_in,
  mhdc_out_if.source                  cell_out,
  input  logic                        write_enable,
  input  logic [mhdc_pkg::INDEX_W-1:0] write_index,
  input  logic [DATA_WIDTH-2:0]       write_data
);
  import mhdc_pkg::*;
  localparam int W = DATA_WIDTH;
  localparam int F = FRAC_BITS;
  localparam int NW = W + F;

  logic [W-2:0] gamma_minus_one;
  logic [W-2:0] pressure_floor;
  logic         en;

  always_ff @(posedge clk) begin
    if (rst) begin
      gamma_minus_one <= (W-1)'(GAMMA_RESET);
      pressure_floor <= (W-1)'(FLOOR_RESET);
    end else if (write_enable) begin
      case (write_index)
        REG_GAMMA: gamma_minus_one <= write_data;
        REG_FLOOR: pressure_floor <= write_data;
        default: ;
      endcase
    end
  end

  assign en = ~cell_out.valid | cell_out.ready;
  assign cell_in.ready = en;

  logic               p_vld, p_negx, p_negy, p_negz, p_derr;
  logic [NW-1:0]      p_numx, p_numy, p_numz;
  logic signed [W-1:0] p_d, p_e, p_bx, p_by, p_bz;
  logic [W-1:0]       abs_x, abs_y, abs_z;

  assign abs_x = cell_in.momentum_x[W-1] ? -cell_in.momentum_x : cell_in.momentum_x;
  assign abs_y = cell_in.momentum_y[W-1] ? -cell_in.momentum_y : cell_in.momentum_y;
  assign abs_z = cell_in.momentum_z[W-1] ? -cell_in.momentum_z : cell_in.momentum_z;

  always_ff @(posedge clk) begin
    if (rst) p_vld <= 1'b0;
    else if (en) p_vld <= cell_in.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_numx <= {abs_x, {F{1'b0}}};
      p_numy <= {abs_y, {F{1'b0}}};
      p_numz <= {abs_z, {F{1'b0}}};
      p_negx <= cell_in.momentum_x[W-1];
      p_negy <= cell_in.momentum_y[W-1];
      p_negz <= cell_in.momentum_z[W-1];
      p_derr <= (cell_in.density <= 0);
      p_d <= cell_in.density;
      p_e <= cell_in.total_energy;
      p_bx <= cell_in.field_x;
      p_by <= cell_in.field_y;
      p_bz <= cell_in.field_z;
    end
  end

  logic [NW-1:0] qx, qy, qz;
  mhdc_div #(.W(W), .F(F)) u_div_x (.clk, .en, .num(p_numx), .den(p_d), .quo(qx));
  mhdc_div #(.W(W), .F(F)) u_div_y (.clk, .en, .num(p_numy), .den(p_d), .quo(qy));
  mhdc_div #(.W(W), .F(F)) u_div_z (.clk, .en, .num(p_numz), .den(p_d), .quo(qz));

  logic               s_vld  [NW];
  logic               s_negx [NW];
  logic               s_negy [NW];
  logic               s_negz [NW];
  logic               s_derr [NW];
  logic signed [W-1:0] s_d   [NW];
  logic signed [W-1:0] s_e   [NW];
  logic signed [W-1:0] s_bx  [NW];
  logic signed [W-1:0] s_by  [NW];
  logic signed [W-1:0] s_bz  [NW];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NW; k++) s_vld[k] <= 1'b0;
    end else if (en) begin
      s_vld[0] <= p_vld;
      for (int k = 1; k < NW; k++) s_vld[k] <= s_vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_negx[0] <= p_negx;
      s_negy[0] <= p_negy;
      s_negz[0] <= p_negz;
      s_derr[0] <= p_derr;
      s_d[0] <= p_d;
      s_e[0] <= p_e;
      s_bx[0] <= p_bx;
      s_by[0] <= p_by;
      s_bz[0] <= p_bz;
      for (int k = 1; k < NW; k++) begin
        s_negx[k] <= s_negx[k-1];
        s_negy[k] <= s_negy[k-1];
        s_negz[k] <= s_negz[k-1];
        s_derr[k] <= s_derr[k-1];
        s_d[k] <= s_d[k-1];
        s_e[k] <= s_e[k-1];
        s_bx[k] <= s_bx[k-1];
        s_by[k] <= s_by[k-1];
        s_bz[k] <= s_bz[k-1];
      end
    end
  end

  mhdc_energy #(.W(W), .F(F)) u_energy (
    .clk, .rst, .en,
    .vld_in(s_vld[NW-1]),
    .quo_x(qx), .quo_y(qy), .quo_z(qz),
    .neg_x(s_negx[NW-1]), .neg_y(s_negy[NW-1]), .neg_z(s_negz[NW-1]),
    .derr_in(s_derr[NW-1]),
    .d_in(s_d[NW-1]), .e_in(s_e[NW-1]),
    .bx_in(s_bx[NW-1]), .by_in(s_by[NW-1]), .bz_in(s_bz[NW-1]),
    .gamma_minus_one, .pressure_floor,
    .vld_out(cell_out.valid),
    .d_out(cell_out.out_density),
    .vx_out(cell_out.velocity_x),
    .vy_out(cell_out.velocity_y),
    .vz_out(cell_out.velocity_z),
    .p_out(cell_out.pressure),
    .bx_out(cell_out.out_field_x),
    .by_out(cell_out.out_field_y),
    .bz_out(cell_out.out_field_z),
    .floor_out(cell_out.floor_applied),
    .derr_out(cell_out.density_error)
  );

`ifndef SYNTHESIS
  a_derr_zero_vel: assert property (@(posedge clk) disable iff (rst)
    cell_out.valid && cell_out.density_error |->
      cell_out.velocity_x == '0 && cell_out.velocity_y == '0 && cell_out.velocity_z == '0)
    else $error("velocity not zero on density error");
  a_derr_sign: assert property (@(posedge clk) disable iff (rst)
    cell_out.valid |-> cell_out.density_error == (cell_out.out_density <= 0))
    else $error("density error flag does not match density");
  a_ready_follow: assert property (@(posedge clk) disable iff (rst)
    cell_in.ready == (!cell_out.valid || cell_out.ready))
    else $error("input ready does not follow output stall");
`endif
endmodule
